>>> sv/compact_tagged_item_decoder_unit_assert.svh
// Assertion macros for the compact tagged item decoder.
`ifndef COMPACT_TAGGED_ITEM_DECODER_UNIT_ASSERT_SVH
`define COMPACT_TAGGED_ITEM_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that the consequent holds in the same cycle as the antecedent.
`define CTID_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("compact tagged item decoder check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CTID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("compact tagged item decoder check failed");

`else

`define CTID_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CTID_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/ctid_pkg.sv
// Package with types and constants of the compact tagged item decoder.
package ctid_pkg;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;
  localparam int KIND_W     = 2;
  localparam int NUMBER_W   = 32;
  localparam int SLEN_W     = 6;
  localparam int BYTE_W     = 8;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_STRING  = 2'd1,
    PH_INTEGER = 2'd2
  } phase_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LITERAL  = 2'd0,
    KIND_STR_HEAD = 2'd1,
    KIND_STR_BYTE = 2'd2,
    KIND_INTEGER  = 2'd3
  } kind_t;

  // Header type codes in bits 7:6.
  localparam logic [1:0] TYPE_STRING  = 2'b00;
  localparam logic [1:0] TYPE_POS_INT = 2'b01;
  localparam logic [1:0] TYPE_NEG_INT = 2'b10;
  localparam logic [1:0] TYPE_LITERAL = 2'b11;

  // Integer size codes in bits 5:4.
  localparam logic [1:0] SIZE_ONE   = 2'b00;
  localparam logic [1:0] SIZE_TWO   = 2'b01;
  localparam logic [1:0] SIZE_THREE = 2'b10;
  localparam logic [1:0] SIZE_FIVE  = 2'b11;

  // Result payload held in the output register.
  typedef struct packed {
    kind_t                kind;
    logic [NUMBER_W-1:0]  number;
    logic [SLEN_W-1:0]    string_length;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 last_of_string;
  } result_t;

endpackage

>>> sv/compact_tagged_item_decoder_unit.sv
// Top level of the compact tagged item decoder: input register, decode, result register.
//
//   channel | direction | tdata                               | tuser        | tlast
//   in_     | slave     | in_byte                             | frame_start  | -
//   out_    | master    | number, string_length, payload_byte | kind         | last_of_string
//
// One byte is taken every cycle while the result register is not stalled; each transfer
// passes the input register and then the result register, from which any result it makes is offered on out_.
// Rate is set by the single decode step between the two registers, which also
// updates the parser state. Reset clears the parser state and both valid flags.
// A stalled result register holds the byte in the input register and then
// drops in_tready; nothing is lost or repeated.
`include "compact_tagged_item_decoder_unit_assert.svh"

module compact_tagged_item_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ctid_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] in_byte
  input  logic                             in_tuser,   // [0] frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ctid_pkg::OUT_DATA_W-1:0]  out_tdata,  // [31:0] number, [37:32] string_length,
                                                       // [45:38] payload_byte, [47:46] zero
  output logic [ctid_pkg::KIND_W-1:0]      out_tuser,  // [1:0] kind
  output logic                             out_tlast   // last_of_string
);
  import ctid_pkg::*;

  // Input register.
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_start_r;

  // Parser state.
  phase_t              phase_r, phase_nxt;
  logic [SLEN_W-1:0]   left_r, left_nxt;
  logic [NUMBER_W-1:0] acc_r, acc_nxt;
  logic                neg_r, neg_nxt;

  // Result register.
  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    emit;

  logic proc_go;

  // A byte is decoded when the result register is free or being emptied.
  assign proc_go   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_go;

  // Input register loads on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata[BYTE_W-1:0];
      in_start_r <= in_tuser;
    end
  end

  // Decode one byte against the parser state.
  always_comb begin
    phase_t              ph;
    logic [SLEN_W-1:0]   lft;
    logic [NUMBER_W-1:0] acc;
    logic [NUMBER_W-1:0] acc_sh;
    logic [SLEN_W-1:0]   lft_dec;
    logic [NUMBER_W-1:0] nib;
    logic                neg_hdr;

    // A frame start abandons any partial item.
    ph      = in_start_r ? PH_HEADER : phase_r;
    lft     = in_start_r ? '0 : left_r;
    acc     = in_start_r ? '0 : acc_r;
    acc_sh  = {acc[NUMBER_W-BYTE_W-1:0], in_byte_r};
    lft_dec = lft - SLEN_W'(1);
    nib     = {{(NUMBER_W-4){1'b0}}, in_byte_r[3:0]};
    neg_hdr = (in_byte_r[7:6] == TYPE_NEG_INT);

    phase_nxt = ph;
    left_nxt  = lft;
    acc_nxt   = acc;
    neg_nxt   = in_start_r ? 1'b0 : neg_r;
    emit      = 1'b0;
    res_nxt   = '0;

    unique case (ph)
      PH_STRING: begin
        left_nxt = lft_dec;
        if (lft_dec == '0) begin
          phase_nxt = PH_HEADER;
        end
        emit                   = 1'b1;
        res_nxt.kind           = KIND_STR_BYTE;
        res_nxt.payload_byte   = in_byte_r;
        res_nxt.last_of_string = (lft_dec == '0);
      end
      PH_INTEGER: begin
        acc_nxt  = acc_sh;
        left_nxt = lft_dec;
        if (lft_dec == '0) begin
          phase_nxt      = PH_HEADER;
          emit           = 1'b1;
          res_nxt.kind   = KIND_INTEGER;
          res_nxt.number = neg_nxt ? ~acc_sh : acc_sh;
        end
      end
      default: begin
        unique case (in_byte_r[7:6])
          TYPE_LITERAL: begin
            emit           = 1'b1;
            res_nxt.kind   = KIND_LITERAL;
            res_nxt.number = {{(NUMBER_W-SLEN_W){1'b0}}, in_byte_r[SLEN_W-1:0]};
          end
          TYPE_STRING: begin
            if (in_byte_r[SLEN_W-1:0] != '0) begin
              phase_nxt = PH_STRING;
              left_nxt  = in_byte_r[SLEN_W-1:0];
            end
            emit                  = 1'b1;
            res_nxt.kind          = KIND_STR_HEAD;
            res_nxt.string_length = in_byte_r[SLEN_W-1:0];
          end
          default: begin
            // Integer header, positive or negative.
            neg_nxt = neg_hdr;
            acc_nxt = nib;
            unique case (in_byte_r[5:4])
              SIZE_ONE: begin
                emit           = 1'b1;
                res_nxt.kind   = KIND_INTEGER;
                res_nxt.number = neg_hdr ? ~nib : nib;
              end
              SIZE_TWO: begin
                left_nxt  = SLEN_W'(1);
                phase_nxt = PH_INTEGER;
              end
              SIZE_THREE: begin
                left_nxt  = SLEN_W'(2);
                phase_nxt = PH_INTEGER;
              end
              default: begin
                // Five-byte form ignores the nibble.
                acc_nxt   = '0;
                left_nxt  = SLEN_W'(4);
                phase_nxt = PH_INTEGER;
              end
            endcase
          end
        endcase
      end
    endcase
  end

  // Parser state advances with each decoded byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      left_r  <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
    end else if (proc_go) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
    end
  end

  // Result register, emptied by an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (proc_go && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.payload_byte, res_r.string_length, res_r.number};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last_of_string;

  // A string or integer in progress always has bytes outstanding.
  `CTID_ASSERT_SAME(a_left_nonzero, clk, rst_n, phase_r != PH_HEADER, left_r != '0)
  // At most four integer bytes follow a header.
  `CTID_ASSERT_SAME(a_int_left_max, clk, rst_n, phase_r == PH_INTEGER, left_r <= SLEN_W'(4))
  // The last mark only accompanies a string payload byte.
  `CTID_ASSERT_SAME(a_last_kind, clk, rst_n, out_valid_r && res_r.last_of_string, res_r.kind == KIND_STR_BYTE)
  // A byte waiting for the result register stays in the input register.
  `CTID_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_r && !proc_go, in_valid_r && $stable(in_byte_r))

endmodule
